// ===== hw/rtl/ipd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ipd_pkg
// Shared types, constants and helpers for the pulse-distance frame decoder.
// ----------------------------------------------------------------------------
package ipd_pkg;

    // Widths fixed by the item and register formats.
    localparam int TICK_W     = 16;
    localparam int WORD_W     = 32;
    localparam int BITPOS_W   = 6;
    localparam int CFG_IDX_W  = 8;
    localparam int FRAME_BITS_DEF = 32;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_START_LOW   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_HIGH  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_LOW  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_HIGH = 8'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_LOW    = 8'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_HIGH   = 8'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_LOW     = 8'd6;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_HIGH    = 8'd7;

    // Register values after reset.
    localparam logic [TICK_W-1:0] RST_START_LOW   = 16'd13000;
    localparam logic [TICK_W-1:0] RST_START_HIGH  = 16'd14000;
    localparam logic [TICK_W-1:0] RST_REPEAT_LOW  = 16'd10750;
    localparam logic [TICK_W-1:0] RST_REPEAT_HIGH = 16'd11750;
    localparam logic [TICK_W-1:0] RST_ZERO_LOW    = 16'd900;
    localparam logic [TICK_W-1:0] RST_ZERO_HIGH   = 16'd1350;
    localparam logic [TICK_W-1:0] RST_ONE_LOW     = 16'd2000;
    localparam logic [TICK_W-1:0] RST_ONE_HIGH    = 16'd2500;

    // Timing windows handed from the register file to the decoder.
    typedef struct packed {
        logic [TICK_W-1:0] start_low;
        logic [TICK_W-1:0] start_high;
        logic [TICK_W-1:0] repeat_low;
        logic [TICK_W-1:0] repeat_high;
        logic [TICK_W-1:0] zero_low;
        logic [TICK_W-1:0] zero_high;
        logic [TICK_W-1:0] one_low;
        logic [TICK_W-1:0] one_high;
    } ipd_cfg_t;

    // An interval matches when low <= t <= high; an inverted window is empty.
    function automatic logic in_window(input logic [TICK_W-1:0] t,
                                       input logic [TICK_W-1:0] lo,
                                       input logic [TICK_W-1:0] hi);
        in_window = (t >= lo) && (t <= hi);
    endfunction

endpackage : ipd_pkg
`default_nettype wire

// ===== hw/rtl/ipd_cfg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ipd_cfg
// Register file for the eight timing window bounds, written over a simple
// valid/ready channel. Indexes beyond the list are ignored.
// ----------------------------------------------------------------------------
module ipd_cfg (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [ipd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ipd_pkg::TICK_W-1:0]    cfg_data,
    output ipd_pkg::ipd_cfg_t                  cfg_out
);
    import ipd_pkg::*;

    ipd_cfg_t cfg_reg;

    // Writes are always taken.
    assign cfg_ready = 1'b1;
    assign cfg_out   = cfg_reg;

    // Register file update.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_low   <= RST_START_LOW;
            cfg_reg.start_high  <= RST_START_HIGH;
            cfg_reg.repeat_low  <= RST_REPEAT_LOW;
            cfg_reg.repeat_high <= RST_REPEAT_HIGH;
            cfg_reg.zero_low    <= RST_ZERO_LOW;
            cfg_reg.zero_high   <= RST_ZERO_HIGH;
            cfg_reg.one_low     <= RST_ONE_LOW;
            cfg_reg.one_high    <= RST_ONE_HIGH;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_START_LOW:   cfg_reg.start_low   <= cfg_data;
                REG_START_HIGH:  cfg_reg.start_high  <= cfg_data;
                REG_REPEAT_LOW:  cfg_reg.repeat_low  <= cfg_data;
                REG_REPEAT_HIGH: cfg_reg.repeat_high <= cfg_data;
                REG_ZERO_LOW:    cfg_reg.zero_low    <= cfg_data;
                REG_ZERO_HIGH:   cfg_reg.zero_high   <= cfg_data;
                REG_ONE_LOW:     cfg_reg.one_low     <= cfg_data;
                REG_ONE_HIGH:    cfg_reg.one_high    <= cfg_data;
                default: begin
                end
            endcase
        end
    end

endmodule : ipd_cfg
`default_nettype wire

// ===== hw/rtl/ipd_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ipd_core
// Input register, phase machine with bit decoding, and result register.
// Both stages advance whenever the result register is free or being taken.
// ----------------------------------------------------------------------------
module ipd_core #(
    parameter int FRAME_BITS = ipd_pkg::FRAME_BITS_DEF
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire ipd_pkg::ipd_cfg_t          cfg,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [ipd_pkg::TICK_W-1:0] s_ticks,
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic                            m_done,
    output logic                            m_repeat,
    output logic [ipd_pkg::WORD_W-1:0]      m_word
);
    import ipd_pkg::*;

    localparam logic [1:0] PH_ARM  = 2'd0;
    localparam logic [1:0] PH_LEAD = 2'd1;
    localparam logic [1:0] PH_DATA = 2'd2;
    localparam logic [1:0] PH_END  = 2'd3;

    localparam logic [BITPOS_W-1:0] BITPOS_LAST = BITPOS_W'(FRAME_BITS - 1);
    localparam int WIDX_W = $clog2(WORD_W);

    logic                in_valid_reg;
    logic [TICK_W-1:0]   ticks_reg;
    logic                out_valid_reg;
    logic                out_done_reg;
    logic                out_rep_reg;
    logic [WORD_W-1:0]   word_reg;
    logic [WORD_W-1:0]   word_next;
    logic [1:0]          phase_reg;
    logic [1:0]          phase_next;
    logic [BITPOS_W-1:0] bitpos_reg;
    logic [BITPOS_W-1:0] bitpos_next;
    logic                done_next;
    logic                rep_next;
    logic                advance;
    logic                fire;
    logic                hit_start;
    logic                hit_repeat;
    logic                hit_zero;
    logic                hit_one;

    // Handshake: the result register frees up when it is empty or taken.
    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    assign m_tvalid = out_valid_reg;
    assign m_done   = out_done_reg;
    assign m_repeat = out_rep_reg;
    assign m_word   = word_reg;

    // Window matches on the registered interval.
    assign hit_start  = in_window(ticks_reg, cfg.start_low, cfg.start_high);
    assign hit_repeat = in_window(ticks_reg, cfg.repeat_low, cfg.repeat_high);
    assign hit_zero   = in_window(ticks_reg, cfg.zero_low, cfg.zero_high);
    assign hit_one    = in_window(ticks_reg, cfg.one_low, cfg.one_high);

    // Phase machine and bit decode for one beat.
    always_comb begin
        phase_next  = phase_reg;
        bitpos_next = bitpos_reg;
        word_next   = word_reg;
        done_next   = 1'b0;
        rep_next    = 1'b0;
        unique case (phase_reg)
            PH_ARM: begin
                phase_next = PH_LEAD;
            end
            PH_LEAD: begin
                if (hit_start) begin
                    phase_next = PH_DATA;
                end else if (hit_repeat) begin
                    rep_next = 1'b1;
                end
            end
            PH_DATA: begin
                // Positions beyond the data word are counted but not stored.
                if (bitpos_reg < BITPOS_W'(WORD_W)) begin
                    if (hit_zero) begin
                        word_next[bitpos_reg[WIDX_W-1:0]] = 1'b0;
                    end else if (hit_one) begin
                        word_next[bitpos_reg[WIDX_W-1:0]] = 1'b1;
                    end
                end
                if (bitpos_reg == '0) begin
                    phase_next = PH_END;
                end else begin
                    bitpos_next = bitpos_reg - BITPOS_W'(1);
                end
            end
            default: begin
                bitpos_next = BITPOS_LAST;
                phase_next  = PH_ARM;
                done_next   = 1'b1;
            end
        endcase
    end

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            ticks_reg <= s_ticks;
        end
    end

    // Decoder state and result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            out_done_reg  <= 1'b0;
            out_rep_reg   <= 1'b0;
            phase_reg     <= PH_ARM;
            bitpos_reg    <= BITPOS_LAST;
            word_reg      <= '0;
        end else begin
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
            if (fire) begin
                out_done_reg <= done_next;
                out_rep_reg  <= rep_next;
                phase_reg    <= phase_next;
                bitpos_reg   <= bitpos_next;
                word_reg     <= word_next;
            end
        end
    end

    // A frame completion and a repeat flag never come on the same beat.
    a_done_rep_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> !(out_done_reg && out_rep_reg))
        else $error("frame_done and repeat_seen set together");

    // An end-phase beat always yields a completed frame.
    a_end_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && phase_reg == PH_END) |=> (out_valid_reg && out_done_reg))
        else $error("end phase beat without frame_done");

    // The data phase never falls straight back to arming.
    a_data_exit: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && phase_reg == PH_DATA) |=> (phase_reg != PH_ARM))
        else $error("data phase left without end phase");

    // The bit counter stays within the frame.
    a_bitpos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        bitpos_reg <= BITPOS_LAST)
        else $error("bit position beyond frame length");

    // A repeat flag only comes from the lead phase.
    a_rep_lead: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && rep_next) |-> (phase_reg == PH_LEAD))
        else $error("repeat flagged outside lead phase");

endmodule : ipd_core
`default_nettype wire

// ===== hw/rtl/ir_pulse_distance_frame_decoder.sv =====
`default_nettype none
// An accepted input beat passes the input register, then the result register.
// Throughput: one input beat per cycle; the input and result registers each
// advance whenever the result register is empty or being taken downstream.
// Reset (aresetn low, synchronous): window registers return to their defaults,
// the decoder returns to the arm phase with a cleared data word, both stages
// empty.
// ----------------------------------------------------------------------------
// ir_pulse_distance_frame_decoder
// Pulse-distance infrared frame decoder: one beat per receiver edge carrying
// the ticks since the previous edge, one result beat per edge.
// ----------------------------------------------------------------------------
module ir_pulse_distance_frame_decoder #(
    parameter int FRAME_BITS = ipd_pkg::FRAME_BITS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // Input stream
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [15:0]                   s_tdata,  // [15:0] elapsed_ticks
    // Result stream
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [31:0]                        m_tdata,  // [31:0] frame_data
    output logic                               m_tlast,  // frame_done
    output logic [0:0]                         m_tuser,  // [0] repeat_seen
    // Configuration writes
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [ipd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ipd_pkg::TICK_W-1:0]    cfg_data
);
    import ipd_pkg::*;

    ipd_cfg_t cfg_windows;

    // Window register file.
    ipd_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_out   (cfg_windows)
    );

    // Decoder pipeline.
    ipd_core #(
        .FRAME_BITS (FRAME_BITS)
    ) u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_windows),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_ticks  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_done   (m_tlast),
        .m_repeat (m_tuser[0]),
        .m_word   (m_tdata)
    );

endmodule : ir_pulse_distance_frame_decoder
`default_nettype wire
